>>> rtl/core/lkvc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ---------------------------------------------------------------------------
package lkvc_pkg;

   localparam int unsigned DepthDef = 16;
   localparam int unsigned KeyWDef  = 64;
   localparam int unsigned ValWDef  = 64;
   localparam int unsigned CapW     = 5;
   localparam logic [CapW-1:0] CapReset = 5'd16;

   // request opcodes
   localparam logic [2:0] OP_GET    = 3'd0;
   localparam logic [2:0] OP_PUT    = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_EXISTS = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // datapath commands issued by the controller
   typedef struct packed {
      logic load;      // capture request, clear scan results
      logic scan;      // examine entry at scan index
      logic scan_rst;  // restart scan index at zero
      logic age;       // rank-update pass step for entry at scan index
      logic evict;     // invalidate the victim entry
      logic write;     // write key/value at target slot
      logic clear_all; // drop every entry
      logic respond;   // drive result strobe
   } lkvc_cmd_type;

   // datapath status back to the controller
   typedef struct packed {
      logic scan_last;  // scan index at last entry
      logic hit;        // key match found
      logic need_evict; // store at capacity
      logic [2:0] op;
   } lkvc_sts_type;

endpackage : lkvc_pkg
`default_nettype wire

>>> rtl/core/lkvc_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_ctrl
// Controller: sequences lookup scan, eviction, rank update, write and response, or a clear.
// ---------------------------------------------------------------------------
module lkvc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output lkvc_pkg::lkvc_cmd_type     cmd,
   input  wire lkvc_pkg::lkvc_sts_type sts
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FIND  = 6'b000010,
      ST_EVICT = 6'b000100,
      ST_AGE   = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next-state and command decode
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cmd.scan_rst = 1'b1;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (sts.op == lkvc_pkg::OP_CLEAR) begin
               cmd.clear_all = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.scan = 1'b1;
               if (sts.scan_last) begin
                  cmd.scan_rst = 1'b1;
                  state_in = ST_EVICT;
               end
            end
         end
         ST_EVICT: begin
            // hit on get/put/delete or a new put: decide path
            if (sts.op == lkvc_pkg::OP_PUT && !sts.hit && sts.need_evict)
               cmd.evict = 1'b1;
            if ((sts.op == lkvc_pkg::OP_GET || sts.op == lkvc_pkg::OP_DELETE) &&
                !sts.hit)
               state_in = ST_RESP;
            else if (sts.op == lkvc_pkg::OP_GET || sts.op == lkvc_pkg::OP_PUT ||
                     sts.op == lkvc_pkg::OP_DELETE)
               state_in = ST_AGE;
            else
               state_in = ST_RESP;
         end
         ST_AGE: begin
            cmd.age = 1'b1;
            if (sts.scan_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !cmd.respond)
      else $error("double response");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy)
      else $error("not busy after load");

endmodule : lkvc_ctrl
`default_nettype wire

>>> rtl/core/lkvc_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_dp
// Datapath: entry storage, sequential scan, rank bookkeeping and result.
// ---------------------------------------------------------------------------
module lkvc_dp #(
   parameter int unsigned DEPTH = lkvc_pkg::DepthDef,
   parameter int unsigned KEY_W = lkvc_pkg::KeyWDef,
   parameter int unsigned VAL_W = lkvc_pkg::ValWDef
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lkvc_pkg::lkvc_cmd_type  cmd,
   output lkvc_pkg::lkvc_sts_type       sts,
   input  wire logic [2:0]              req_op,
   input  wire logic [63:0]             req_key,
   input  wire logic [63:0]             req_data_in,
   input  wire logic                    csr_we,
   input  wire logic [4:0]              csr_wdata,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [63:0]                  rsp_data_out,
   output logic                         rsp_evicted,
   output logic [4:0]                   rsp_count
);

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // entry storage
   logic [KEY_W-1:0] key_mem [DEPTH];
   logic [VAL_W-1:0] val_mem [DEPTH];
   logic [IW-1:0]    rank_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [CW-1:0]    count_ff;
   logic [4:0]       cap_ff;

   // request and scan registers
   logic [2:0]       op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;
   logic [IW-1:0]    idx_ff;
   logic             hit_ff, free_ok_ff, victim_ok_ff, evicted_ff;
   logic [IW-1:0]    hit_idx_ff, free_idx_ff, victim_idx_ff;
   logic [IW-1:0]    ref_rank_ff;
   logic [VAL_W-1:0] dout_ff;
   logic             rsp_valid_ff;
   logic [CW-1:0]    cap_eff;

   // clamp capacity to 1..DEPTH
   always_comb begin
      if (cap_ff == 5'd0) cap_eff = CW'(1);
      else if (32'(cap_ff) > DEPTH) cap_eff = CW'(DEPTH);
      else cap_eff = CW'(cap_ff);
   end

   logic scan_match, scan_victim;
   assign scan_match  = valid_ff[idx_ff] && (key_mem[idx_ff] == key_ff);
   assign scan_victim = valid_ff[idx_ff] && ((CW'(rank_ff[idx_ff]) + CW'(1)) == count_ff);

   assign sts.scan_last  = (32'(idx_ff) == DEPTH - 1);
   assign sts.hit        = hit_ff;
   assign sts.need_evict = (count_ff >= cap_eff);
   assign sts.op         = op_ff;

   // rank reference: hit entry rank for move/remove, victim rank on evict
   logic is_put_new;
   assign is_put_new = (op_ff == lkvc_pkg::OP_PUT) && !hit_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         key_ff <= req_key[KEY_W-1:0];
         val_ff <= req_data_in[VAL_W-1:0];
         hit_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         victim_ok_ff <= 1'b0;
         evicted_ff <= 1'b0;
         dout_ff <= '0;
      end
      if (cmd.scan_rst) idx_ff <= '0;
      else if (cmd.scan || cmd.age) idx_ff <= idx_ff + IW'(1);
      // lookup pass: match, first free, victim
      if (cmd.scan) begin
         if (scan_match && !hit_ff) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= idx_ff;
            ref_rank_ff <= rank_ff[idx_ff];
            if (op_ff == lkvc_pkg::OP_GET) dout_ff <= val_mem[idx_ff];
         end
         if (!valid_ff[idx_ff] && !free_ok_ff) begin
            free_ok_ff <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (scan_victim && !victim_ok_ff) begin
            victim_ok_ff <= 1'b1;
            victim_idx_ff <= idx_ff;
         end
      end
      if (cmd.evict) begin
         evicted_ff <= victim_ok_ff;
         if (victim_ok_ff) begin
            ref_rank_ff <= rank_ff[victim_idx_ff];
            // victim slot becomes the fill slot when no earlier free slot
            if (!free_ok_ff || victim_idx_ff < free_idx_ff) free_idx_ff <= victim_idx_ff;
            free_ok_ff <= 1'b1;
         end
      end
   end

   // storage and rank update
   always_ff @(posedge clock) begin
      if (cmd.write && is_put_new && free_ok_ff) begin
         key_mem[free_idx_ff] <= key_ff;
         val_mem[free_idx_ff] <= val_ff;
      end else if (cmd.write && op_ff == lkvc_pkg::OP_PUT && hit_ff) begin
         val_mem[hit_idx_ff] <= val_ff;
      end
      if (cmd.age && valid_ff[idx_ff]) begin
         if (is_put_new) begin
            // evicted entry's rank is the largest, so only aging remains
            if (!(evicted_ff && idx_ff == victim_idx_ff))
               rank_ff[idx_ff] <= rank_ff[idx_ff] + IW'(1);
         end else if (op_ff == lkvc_pkg::OP_DELETE) begin
            if (rank_ff[idx_ff] > ref_rank_ff)
               rank_ff[idx_ff] <= rank_ff[idx_ff] - IW'(1);
         end else if (idx_ff == hit_idx_ff) begin
            rank_ff[idx_ff] <= '0;
         end else if (rank_ff[idx_ff] < ref_rank_ff) begin
            rank_ff[idx_ff] <= rank_ff[idx_ff] + IW'(1);
         end
      end
      if (cmd.write && is_put_new && free_ok_ff) rank_ff[free_idx_ff] <= '0;
   end

   // valid bits, count, capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         cap_ff   <= lkvc_pkg::CapReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (csr_we) cap_ff <= csr_wdata;
         if (cmd.clear_all) begin
            valid_ff <= '0;
            count_ff <= '0;
         end else if (cmd.evict && victim_ok_ff) begin
            valid_ff[victim_idx_ff] <= 1'b0;
            count_ff <= count_ff - CW'(1);
         end else if (cmd.write && is_put_new && free_ok_ff) begin
            valid_ff[free_idx_ff] <= 1'b1;
            count_ff <= count_ff + CW'(1);
         end else if (cmd.write && op_ff == lkvc_pkg::OP_DELETE && hit_ff) begin
            valid_ff[hit_idx_ff] <= 1'b0;
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   // registered result
   logic found_ff;
   logic [63:0] dout_out_ff;
   logic [4:0]  cnt_out_ff;
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         found_ff    <= hit_ff && (op_ff != lkvc_pkg::OP_CLEAR) &&
                        (op_ff <= lkvc_pkg::OP_EXISTS);
         dout_out_ff <= 64'(dout_ff);
         cnt_out_ff  <= 5'(count_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_data_out = dout_out_ff;
   assign rsp_evicted  = evicted_ff;
   assign rsp_count    = cnt_out_ff;

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(valid_ff)))
      else $error("count out of step with valid bits");
   a_evict_put: assert property (@(posedge clock) disable iff (reset)
      cmd.evict && victim_ok_ff |-> op_ff == lkvc_pkg::OP_PUT && !hit_ff)
      else $error("eviction outside new put");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("count beyond depth");

endmodule : lkvc_dp
`default_nettype wire

>>> rtl/core/lru_key_value_cache_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Usage: drive req_op/req_key/req_data_in and pulse start while busy is low;
// the transaction is taken at that edge and busy rises. Ops: get, put,
// delete, exists, clear. Each transaction yields exactly one result, shown
// for one cycle with rsp_valid high; the receiver cannot stall it.
// Sequence: a scan of every entry for match/free/victim, a decision step, a
// rank update pass over every entry for get/put/delete hits and new puts, a
// write step and a response step. Exists and get/delete misses skip the rank
// pass and write; clear instead drops all entries, then responds.
// One transaction at a time; both scans use the one entry index counter.
// csr_we/csr_wdata set the capacity (reset 16, clamped to 1..DEPTH); write
// it only while idle. Reset empties the store and returns to idle.
// ---------------------------------------------------------------------------
module lru_key_value_cache_top #(
   parameter int unsigned DEPTH = lkvc_pkg::DepthDef,
   parameter int unsigned KEY_W = lkvc_pkg::KeyWDef,
   parameter int unsigned VAL_W = lkvc_pkg::ValWDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_op,
   input  wire logic [63:0] req_key,
   input  wire logic [63:0] req_data_in,
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata,
   output logic             rsp_valid,
   output logic             rsp_found,
   output logic [63:0]      rsp_data_out,
   output logic             rsp_evicted,
   output logic [4:0]       rsp_count
);

   lkvc_pkg::lkvc_cmd_type cmd;
   lkvc_pkg::lkvc_sts_type sts;

   lkvc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .sts(sts)
   );

   lkvc_dp #(.DEPTH(DEPTH), .KEY_W(KEY_W), .VAL_W(VAL_W)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_op(req_op), .req_key(req_key), .req_data_in(req_data_in),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found), .rsp_data_out(rsp_data_out),
      .rsp_evicted(rsp_evicted), .rsp_count(rsp_count)
   );

endmodule : lru_key_value_cache_top
`default_nettype wire
